// File: rtl/core/circular_list_insert_delete_top_macros.svh
// Assertion macros used by the circular list checker.
`ifndef CIRCULAR_LIST_INSERT_DELETE_TOP_MACROS_SVH
`define CIRCULAR_LIST_INSERT_DELETE_TOP_MACROS_SVH

// Check a consequence in the same cycle as its trigger.
`define CLL_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("circular list port check failed");

// Check a consequence in the cycle after its trigger.
`define CLL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("circular list port check failed");

`endif

// File: rtl/core/cll_pkg.sv
// Shared types, codes and constants for the circular list block.
package cll_pkg;

    // Default node pool size and fixed port widths
    localparam int CAPACITY_DEF = 16;
    localparam int POS_W        = 5;
    localparam int COUNT_W      = 5;
    localparam int DATA_W       = 32;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_DELETE = 2'd1,
        MODE_DUMP   = 2'd2,
        MODE_RSVD   = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        RS_OK        = 3'd0,
        RS_BAD_POS   = 3'd1,
        RS_NOT_FOUND = 3'd2,
        RS_EMPTY     = 3'd3,
        RS_FULL      = 3'd4
    } res_status_t;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_DECIDE,
        CS_PRIME,
        CS_WALK,
        CS_LINK,
        CS_DONE
    } ctrl_state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic        latch;
        logic        load;
        logic        prime;
        logic        step;
        logic        first_node;
        logic        ins_link;
        logic        ins_commit;
        logic        del_node;
        logic        emit;
        logic        emit_elem;
        logic        emit_last;
        res_status_t emit_status;
    } cll_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        mode_t mode;
        logic  pos_bad;
        logic  full;
        logic  empty;
        logic  at_pos;
        logic  match;
        logic  last_node;
    } cll_stat_t;

endpackage

// File: rtl/core/cll_datapath.sv
// Node pool, list pointers, link walker and result registers.
module cll_datapath #(
    parameter int CAPACITY = cll_pkg::CAPACITY_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  cll_pkg::cll_cmd_t                 cmd,
    output cll_pkg::cll_stat_t                stat,
    input  logic [1:0]                        mode,
    input  logic signed [cll_pkg::DATA_W-1:0] value,
    input  logic [cll_pkg::POS_W-1:0]         position,
    output logic                              strobe,
    output logic [2:0]                        status,
    output logic signed [cll_pkg::DATA_W-1:0] element,
    output logic [cll_pkg::COUNT_W-1:0]       element_count,
    output logic                              last_result
);
    import cll_pkg::*;

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;

    // Latched item
    mode_t               mode_reg;
    logic [DATA_W-1:0]   key_reg;
    logic [POS_W-1:0]    pos_reg;
    logic [IW-1:0]       slot_reg;

    // List state
    logic [CAPACITY-1:0] free_reg, free_next;
    logic [IW-1:0]       tail_reg, tail_next;
    logic [CW-1:0]       total_reg, total_next;

    // Walker
    logic [IW-1:0]       ptr_reg;
    logic [IW-1:0]       cur_reg;
    logic [CW-1:0]       idx_reg;

    // Node pool with registered reads
    logic [DATA_W-1:0]   value_mem [CAPACITY];
    logic [IW-1:0]       link_mem [CAPACITY];
    logic [DATA_W-1:0]   val_rd_reg;
    logic [IW-1:0]       link_rd_reg;
    logic [IW-1:0]       rd_addr;
    logic                link_we;
    logic [IW-1:0]       link_waddr;
    logic [IW-1:0]       link_wdata;
    logic                val_we;

    // Result beat
    logic                strobe_reg;
    res_status_t         status_reg;
    logic [DATA_W-1:0]   element_reg;
    logic [CW-1:0]       ecount_reg;
    logic                last_reg;

    logic [IW-1:0]       low_free;
    logic                count_one;
    logic                at_end;
    logic [PW-1:0]       pos_ext;
    logic [PW-1:0]       total_ext;
    logic [CW+COUNT_W-1:0] ecount_ext;

    // Pick the lowest free node
    always_comb
    begin
        low_free = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (free_reg[i])
            begin
                low_free = IW'(i);
            end
        end
    end

    // Derive walk and range flags
    assign pos_ext   = PW'(pos_reg);
    assign total_ext = PW'(total_reg);
    assign count_one = (total_reg == CW'(1));
    assign at_end    = (pos_ext == total_ext + PW'(1));

    always_comb
    begin
        stat.mode      = mode_reg;
        stat.pos_bad   = (pos_reg == '0) || (pos_ext > total_ext + PW'(1));
        stat.full      = (total_reg == CW'(CAPACITY));
        stat.empty     = (total_reg == '0);
        stat.at_pos    = (PW'(idx_reg) + PW'(1) == pos_ext);
        stat.match     = (val_rd_reg == key_reg);
        stat.last_node = (idx_reg + CW'(1) == total_reg);
    end

    // Capture the item and the node it may take
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            mode_reg <= mode_t'(mode);
            key_reg  <= value;
            pos_reg  <= position;
            slot_reg <= low_free;
        end
    end

    // Advance the walker along the links
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ptr_reg <= tail_reg;
        end
        if (cmd.prime)
        begin
            cur_reg <= link_rd_reg;
            idx_reg <= '0;
        end
        if (cmd.step)
        begin
            ptr_reg <= cur_reg;
            cur_reg <= link_rd_reg;
            idx_reg <= idx_reg + CW'(1);
        end
    end

    // Chase the link just read, or start at the tail
    assign rd_addr = cmd.load ? tail_reg : link_rd_reg;

    // Select the link write for each list edit
    always_comb
    begin
        link_we    = 1'b0;
        link_waddr = slot_reg;
        link_wdata = slot_reg;
        if (cmd.first_node)
        begin
            link_we = 1'b1;
        end
        if (cmd.ins_link)
        begin
            link_we    = 1'b1;
            link_wdata = cur_reg;
        end
        if (cmd.ins_commit)
        begin
            link_we    = 1'b1;
            link_waddr = ptr_reg;
        end
        if (cmd.del_node && !count_one)
        begin
            link_we    = 1'b1;
            link_waddr = ptr_reg;
            link_wdata = link_rd_reg;
        end
    end

    assign val_we = cmd.first_node | cmd.ins_link;

    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        if (val_we)
        begin
            value_mem[slot_reg] <= key_reg;
        end
        link_rd_reg <= link_mem[rd_addr];
        val_rd_reg  <= value_mem[rd_addr];
    end

    // Update tail, node count and free map
    always_comb
    begin
        tail_next  = tail_reg;
        total_next = total_reg;
        free_next  = free_reg;
        if (cmd.first_node)
        begin
            tail_next           = slot_reg;
            total_next          = total_reg + CW'(1);
            free_next[slot_reg] = 1'b0;
        end
        if (cmd.ins_commit)
        begin
            if (at_end)
            begin
                tail_next = slot_reg;
            end
            total_next          = total_reg + CW'(1);
            free_next[slot_reg] = 1'b0;
        end
        if (cmd.del_node)
        begin
            if (count_one)
            begin
                tail_next = '0;
            end
            else if (cur_reg == tail_reg)
            begin
                tail_next = ptr_reg;
            end
            total_next         = total_reg - CW'(1);
            free_next[cur_reg] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tail_reg  <= '0;
            total_reg <= '0;
            free_reg  <= '1;
        end
        else
        begin
            tail_reg  <= tail_next;
            total_reg <= total_next;
            free_reg  <= free_next;
        end
    end

    // Drive one result beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            status_reg  <= cmd.emit_status;
            element_reg <= cmd.emit_elem ? val_rd_reg : '0;
            ecount_reg  <= total_reg;
            last_reg    <= cmd.emit_last;
        end
    end

    assign ecount_ext    = {{COUNT_W{1'b0}}, ecount_reg};
    assign strobe        = strobe_reg;
    assign status        = status_reg;
    assign element       = element_reg;
    assign element_count = ecount_ext[COUNT_W-1:0];
    assign last_result   = last_reg;

endmodule

// File: rtl/core/cll_ctrl.sv
// Controller state machine that sequences insert, delete and dump.
module cll_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  cll_pkg::cll_stat_t stat,
    output logic               busy,
    output cll_pkg::cll_cmd_t  cmd
);
    import cll_pkg::*;

    ctrl_state_t state_reg, state_next;

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != CS_IDLE);

    // Decide the next state and the datapath commands
    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.emit_last   = 1'b1;
        cmd.emit_status = RS_OK;
        case (state_reg)
            CS_IDLE:
            begin
                if (start)
                begin
                    cmd.latch  = 1'b1;
                    state_next = CS_DECIDE;
                end
            end
            CS_DECIDE:
            begin
                state_next = CS_IDLE;
                case (stat.mode)
                    MODE_INSERT:
                    begin
                        if (stat.pos_bad)
                        begin
                            cmd.emit        = 1'b1;
                            cmd.emit_status = RS_BAD_POS;
                        end
                        else if (stat.full)
                        begin
                            cmd.emit        = 1'b1;
                            cmd.emit_status = RS_FULL;
                        end
                        else if (stat.empty)
                        begin
                            cmd.first_node = 1'b1;
                            state_next     = CS_DONE;
                        end
                        else
                        begin
                            cmd.load   = 1'b1;
                            state_next = CS_PRIME;
                        end
                    end
                    MODE_DELETE, MODE_DUMP:
                    begin
                        if (stat.empty)
                        begin
                            cmd.emit        = 1'b1;
                            cmd.emit_status = RS_EMPTY;
                        end
                        else
                        begin
                            cmd.load   = 1'b1;
                            state_next = CS_PRIME;
                        end
                    end
                    default:
                    begin
                        cmd.emit = 1'b1;
                    end
                endcase
            end
            CS_PRIME:
            begin
                cmd.prime  = 1'b1;
                state_next = CS_WALK;
            end
            CS_WALK:
            begin
                case (stat.mode)
                    MODE_INSERT:
                    begin
                        if (stat.at_pos)
                        begin
                            cmd.ins_link = 1'b1;
                            state_next   = CS_LINK;
                        end
                        else
                        begin
                            cmd.step = 1'b1;
                        end
                    end
                    MODE_DELETE:
                    begin
                        if (stat.match)
                        begin
                            cmd.del_node = 1'b1;
                            state_next   = CS_DONE;
                        end
                        else if (stat.last_node)
                        begin
                            cmd.emit        = 1'b1;
                            cmd.emit_status = RS_NOT_FOUND;
                            state_next      = CS_IDLE;
                        end
                        else
                        begin
                            cmd.step = 1'b1;
                        end
                    end
                    MODE_DUMP:
                    begin
                        cmd.emit      = 1'b1;
                        cmd.emit_elem = 1'b1;
                        cmd.emit_last = stat.last_node;
                        if (stat.last_node)
                        begin
                            state_next = CS_IDLE;
                        end
                        else
                        begin
                            cmd.step = 1'b1;
                        end
                    end
                    default:
                    begin
                        state_next = CS_IDLE;
                    end
                endcase
            end
            CS_LINK:
            begin
                cmd.ins_commit = 1'b1;
                state_next     = CS_DONE;
            end
            CS_DONE:
            begin
                cmd.emit   = 1'b1;
                state_next = CS_IDLE;
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/circular_list_insert_delete_top.sv
// Circular singly linked list over a fixed node pool: insert at a 1-based position,
// delete the first match, or dump the list from the head. Raise start while busy is
// low to hand in one beat; each result beat shows on the result ports for one cycle
// with strobe high and cannot be held off. A rejected or reserved beat is answered
// straight from the decide state. An insert into an empty list takes no link walk;
// an insert at position p into a non-empty list, a delete and a dump walk the links
// from the head, and a dump of n nodes gives one result beat per cycle. The walk is
// paced by the node pool, which reads one link per cycle through its registered port.
module circular_list_insert_delete_top #(
    parameter int CAPACITY = cll_pkg::CAPACITY_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        mode,
    input  logic signed [cll_pkg::DATA_W-1:0] value,
    input  logic [cll_pkg::POS_W-1:0]         position,
    output logic                              strobe,
    output logic [2:0]                        status,
    output logic signed [cll_pkg::DATA_W-1:0] element,
    output logic [cll_pkg::COUNT_W-1:0]       element_count,
    output logic                              last_result
);
    import cll_pkg::*;

    cll_cmd_t  cmd;
    cll_stat_t stat;

    // Sequence each operation
    cll_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start & ~busy),
        .stat  (stat),
        .busy  (busy),
        .cmd   (cmd)
    );

    // Hold the node pool and drive results
    cll_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .mode          (mode),
        .value         (value),
        .position      (position),
        .strobe        (strobe),
        .status        (status),
        .element       (element),
        .element_count (element_count),
        .last_result   (last_result)
    );

endmodule

// File: rtl/core/cll_checker.sv
// Port-level checks for the circular list block, bound to its top level.
`include "circular_list_insert_delete_top_macros.svh"

module cll_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              start,
    input logic                              busy,
    input logic                              strobe,
    input logic [2:0]                        status,
    input logic signed [cll_pkg::DATA_W-1:0] element,
    input logic [cll_pkg::COUNT_W-1:0]       element_count,
    input logic                              last_result
);
    import cll_pkg::*;

    // An error answers with a single beat and no element
    `CLL_ASSERT_IMPL(a_err_single, strobe && (status != RS_OK), last_result && (element == '0))

    // Dump beats come back to back until the last one
    `CLL_ASSERT_NEXT(a_dump_burst, strobe && !last_result, strobe)

    // Mid-dump beats are ok and the block is still working
    `CLL_ASSERT_IMPL(a_burst_busy, strobe && !last_result, busy && (status == RS_OK))

    // An empty answer reports no nodes
    `CLL_ASSERT_IMPL(a_empty_zero, strobe && (status == RS_EMPTY), element_count == '0)

    // A taken beat makes the block busy
    `CLL_ASSERT_NEXT(a_accept_busy, start && !busy, busy)

endmodule

bind circular_list_insert_delete_top cll_checker u_cll_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .strobe        (strobe),
    .status        (status),
    .element       (element),
    .element_count (element_count),
    .last_result   (last_result)
);
